FILE: hw/rtl/key_weighted_sum_hash_macros.svh
// ----------------------------------------------------------------------------
// key_weighted_sum_hash assertion macros
// Shared assertion wrappers for the hash block's checker.
// ----------------------------------------------------------------------------
`ifndef KEY_WEIGHTED_SUM_HASH_MACROS_SVH
`define KEY_WEIGHTED_SUM_HASH_MACROS_SVH

// check a property outside reset
`define KWSH_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property at every edge, reset included
`define KWSH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/kwsh_pkg.sv
// ----------------------------------------------------------------------------
// kwsh_pkg
// Types and constants shared by the weighted-sum key hash modules.
// ----------------------------------------------------------------------------
package kwsh_pkg;

  localparam int CP_W      = 21;
  localparam int POS_W     = 16;
  localparam int SUM_W     = 64;
  localparam int CAP_W     = 32;
  localparam int MUL_W     = POS_W + CP_W;
  localparam int PROD_W    = MUL_W + 1;
  localparam int DIV_CNT_W = 6;

  localparam logic [POS_W-1:0] POS_LIMIT = '1;
  localparam logic [CAP_W-1:0] CAP_RESET = 32'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_LAST,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic take;
    logic add;
    logic end_load;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

FILE: hw/rtl/key_weighted_sum_hash.sv
// Sequence: a key's closing item is followed by the close step, the remainder
// steps over the 64-bit sum and the output load.
// Throughput: one character per cycle inside a key; the bit-serial remainder
// unit holds intake from a key's close until its result is loaded, and that
// load waits while an earlier result still waits at the output.
// Reset: rst (synchronous) clears key state, output valid, and sets capacity 16.
// ----------------------------------------------------------------------------
// key_weighted_sum_hash
// Position-weighted character-sum hash reduced modulo the bucket count.
// ----------------------------------------------------------------------------
module key_weighted_sum_hash #(
  parameter int unsigned MAX_KEY_CHARS = 65535
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [20:0] code_point, [23:21] zero
  input  logic        s_axis_tlast,
  input  logic        s_axis_tuser,   // [0] empty_key
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] bucket_index
  output logic        m_axis_tuser    // [0] too_long
);

  kwsh_pkg::cmd_t cmd;
  kwsh_pkg::sts_t sts;

  kwsh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_end   (s_axis_tlast || s_axis_tuser),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kwsh_dp #(
    .MAX_KEY_CHARS (MAX_KEY_CHARS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .code_point   (s_axis_tdata[kwsh_pkg::CP_W-1:0]),
    .empty_key    (s_axis_tuser),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .bucket_index (m_axis_tdata),
    .too_long     (m_axis_tuser)
  );

endmodule

FILE: hw/rtl/kwsh_div.sv
// ----------------------------------------------------------------------------
// kwsh_div
// Restoring remainder unit: 64-bit dividend by 32-bit divisor, one bit a cycle while step is high.
// ----------------------------------------------------------------------------
module kwsh_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  logic                              step,
  input  logic [kwsh_pkg::SUM_W-1:0]        num_in,
  input  logic [kwsh_pkg::CAP_W-1:0]        divisor,
  output logic [kwsh_pkg::CAP_W-1:0]        rem,
  output logic                              last
);

  logic [kwsh_pkg::SUM_W-1:0]     num;
  logic [kwsh_pkg::DIV_CNT_W-1:0] cnt;
  logic [kwsh_pkg::CAP_W:0]       trial;
  logic [kwsh_pkg::CAP_W:0]       diff;

  assign trial = {rem, num[kwsh_pkg::SUM_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign last  = (cnt == '1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= '0;
    end else if (step) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      num <= num_in;
      rem <= '0;
    end else if (step) begin
      num <= {num[kwsh_pkg::SUM_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem <= diff[kwsh_pkg::CAP_W-1:0];
      end else begin
        rem <= trial[kwsh_pkg::CAP_W-1:0];
      end
    end
  end

endmodule

FILE: hw/rtl/kwsh_dp.sv
// ----------------------------------------------------------------------------
// kwsh_dp
// Datapath: capacity register, position counter, weighted accumulator,
// remainder unit and output register.
// ----------------------------------------------------------------------------
module kwsh_dp #(
  parameter int unsigned MAX_KEY_CHARS = 65535
) (
  input  logic                         clk,
  input  logic                         rst,
  input  kwsh_pkg::cmd_t               cmd,
  output kwsh_pkg::sts_t               sts,
  input  logic                         cfg_wr_en,
  input  logic [kwsh_pkg::CAP_W-1:0]   cfg_wr_data,
  input  logic [kwsh_pkg::CP_W-1:0]    code_point,
  input  logic                         empty_key,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [kwsh_pkg::CAP_W-1:0]   bucket_index,
  output logic                         too_long
);

  localparam logic [kwsh_pkg::POS_W-1:0] BOUND =
    (MAX_KEY_CHARS < 32'(kwsh_pkg::POS_LIMIT)) ? kwsh_pkg::POS_W'(MAX_KEY_CHARS)
                                               : kwsh_pkg::POS_LIMIT;

  logic [kwsh_pkg::CAP_W-1:0]  cap;
  logic [kwsh_pkg::POS_W-1:0]  pos;
  logic [kwsh_pkg::POS_W-1:0]  pos_inc;
  logic [kwsh_pkg::SUM_W-1:0]  sum;
  logic [kwsh_pkg::SUM_W-1:0]  sum_next;
  logic [kwsh_pkg::PROD_W-1:0] prod;
  logic [kwsh_pkg::MUL_W-1:0]  mult;
  logic                        ovf;
  logic                        div_ovf;
  logic                        full;
  logic [kwsh_pkg::CAP_W-1:0]  rem;
  logic                        div_last;

  assign full     = (pos >= BOUND);
  assign pos_inc  = pos + 1'b1;
  assign mult     = {{kwsh_pkg::CP_W{1'b0}}, pos_inc} *
                    {{kwsh_pkg::POS_W{1'b0}}, code_point};
  assign sum_next = sum + kwsh_pkg::SUM_W'(prod);

  assign sts.div_last = div_last;
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= kwsh_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      cap <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      sum <= '0;
      ovf <= 1'b0;
    end else if (cmd.end_load) begin
      pos <= '0;
      sum <= '0;
      ovf <= 1'b0;
    end else begin
      if (cmd.add) begin
        sum <= sum_next;
      end
      if (cmd.take && !empty_key) begin
        if (full) begin
          ovf <= 1'b1;
        end else begin
          pos <= pos_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      if (empty_key || full) begin
        prod <= '0;
      end else begin
        prod <= {mult, 1'b0};
      end
    end
    if (cmd.end_load) begin
      div_ovf <= ovf;
    end
  end

  kwsh_div u_div (
    .clk     (clk),
    .rst     (rst),
    .load    (cmd.end_load),
    .step    (cmd.div_step),
    .num_in  (sum_next),
    .divisor (cap),
    .rem     (rem),
    .last    (div_last)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      bucket_index <= (cap == '0) ? '0 : rem;
      too_long     <= div_ovf;
    end
  end

endmodule

FILE: hw/rtl/kwsh_ctrl.sv
// ----------------------------------------------------------------------------
// kwsh_ctrl
// Controller: sequences character intake, key close, remainder and output.
// ----------------------------------------------------------------------------
module kwsh_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_end,
  output logic            in_ready,
  input  kwsh_pkg::sts_t  sts,
  output kwsh_pkg::cmd_t  cmd
);

  kwsh_pkg::state_t state;
  kwsh_pkg::state_t state_next;
  logic             accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kwsh_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      kwsh_pkg::ST_IDLE, kwsh_pkg::ST_ACC: begin
        if (accept) begin
          state_next = in_end ? kwsh_pkg::ST_LAST : kwsh_pkg::ST_ACC;
        end else begin
          state_next = kwsh_pkg::ST_IDLE;
        end
      end
      kwsh_pkg::ST_LAST: begin
        state_next = kwsh_pkg::ST_DIV;
      end
      kwsh_pkg::ST_DIV: begin
        if (sts.div_last) begin
          state_next = kwsh_pkg::ST_DONE;
        end
      end
      kwsh_pkg::ST_DONE: begin
        if (sts.out_free) begin
          state_next = kwsh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = kwsh_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      kwsh_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      kwsh_pkg::ST_ACC: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        cmd.add  = 1'b1;
      end
      kwsh_pkg::ST_LAST: begin
        cmd.end_load = 1'b1;
      end
      kwsh_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      kwsh_pkg::ST_DONE: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

FILE: hw/rtl/kwsh_chk.sv
// ----------------------------------------------------------------------------
// kwsh_chk
// Port-level checker for the weighted-sum key hash, bound to the top level.
// ----------------------------------------------------------------------------
`include "key_weighted_sum_hash_macros.svh"

module kwsh_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  `KWSH_ASSERT_ALWAYS(a_rst_no_out, clk, rst |=> !m_axis_tvalid, "output valid after reset")
  `KWSH_ASSERT_ALWAYS(a_rst_ready, clk, rst |=> s_axis_tready, "input not ready after reset")
  `KWSH_ASSERT(a_end_busy, clk, rst,
    (s_axis_tvalid && s_axis_tready && (s_axis_tlast || s_axis_tuser)) |=> !s_axis_tready,
    "input taken right after key close")
  `KWSH_ASSERT(a_out_hold, clk, rst,
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)),
    "stalled result changed")

endmodule

bind key_weighted_sum_hash kwsh_chk u_kwsh_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
